// ----- src/password_door_lock_controller_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the lock controller
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PASSWORD_DOOR_LOCK_CONTROLLER_TOP_MACROS_SVH
`define PASSWORD_DOOR_LOCK_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// check sampled on clk, switched off while reset is active
`define PDLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check sampled on clk, active during reset as well
`define PDLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PDLC_ASSERT(lbl, prop, msg)
`define PDLC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- src/pdlc_pkg.sv -----
// ----------------------------------------------------------------------------
// Lock controller package
// Shared constants, command codes and the result and memory request structs.
// ----------------------------------------------------------------------------
package pdlc_pkg;

  // password length and key index width
  localparam int PASS_LEN = 5;
  localparam int IDX_W    = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
  localparam logic [IDX_W:0] PASS_LEN_C = (IDX_W + 1)'(PASS_LEN);

  // command bytes
  localparam logic [7:0] CMD_SET   = 8'h23;
  localparam logic [7:0] CMD_CHECK = 8'h24;
  localparam logic [7:0] CMD_DOOR  = 8'h25;
  localparam logic [7:0] CMD_ALARM = 8'h26;

  // item kinds on the input tuser
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // motor drive codes
  localparam logic [1:0] MOTOR_STOP = 2'd0;
  localparam logic [1:0] MOTOR_CW   = 2'd1;
  localparam logic [1:0] MOTOR_CCW  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_OPEN  = 2'd0;
  localparam logic [1:0] CFG_HOLD  = 2'd1;
  localparam logic [1:0] CFG_CLOSE = 2'd2;
  localparam logic [1:0] CFG_ALARM = 2'd3;

  // reset values of the tick registers
  localparam logic [7:0] OPEN_TICKS_RST  = 8'd6;
  localparam logic [7:0] HOLD_TICKS_RST  = 8'd2;
  localparam logic [7:0] CLOSE_TICKS_RST = 8'd6;
  localparam logic [7:0] ALARM_TICKS_RST = 8'd21;

  localparam int OUT_W = 8;

  // result word, tx_valid in the lowest bit
  typedef struct packed {
    logic       busy_res;
    logic       alarm_buzz;
    logic [1:0] motor_drive;
    logic       tx_code;
    logic       tx_valid;
  } res_t;

  // password memory request: one write and one read address
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- src/pdlc_mem.sv -----
// ----------------------------------------------------------------------------
// Password memory
// One write and one registered read per cycle, per-entry valid bits so that
// unwritten entries read as zero, and write-to-read forwarding.
// ----------------------------------------------------------------------------
module pdlc_mem
  import pdlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mem_req_t   req,
  output logic [7:0] rd_data_r
);

  logic [7:0]          mem_r [PASS_LEN];
  logic [PASS_LEN-1:0] valid_r;

  // storage write
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  // registered read with forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_data_r <= '0;
    end else if (req.we && (req.waddr == req.raddr)) begin
      rd_data_r <= req.wdata;
    end else if (valid_r[req.raddr]) begin
      rd_data_r <= mem_r[req.raddr];
    end else begin
      rd_data_r <= '0;
    end
  end

endmodule

// ----- src/pdlc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Lock controller sequencer
// Command decode, key entry and compare, timed door and alarm phases, and
// the tick length registers.
// ----------------------------------------------------------------------------
module pdlc_ctrl
  import pdlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       acc,
  input  logic       func,
  input  logic [7:0] rx_byte,
  input  logic [7:0] rd_data,
  output mem_req_t   mem_req,
  output res_t       res
);

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_NEW1, MODE_NEW2, MODE_CHECK,
    MODE_OPEN, MODE_HOLD, MODE_CLOSE, MODE_ALARM
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [IDX_W-1:0] key_r, key_nxt;
  logic             mis_r, mis_nxt;
  logic [7:0]       tick_r, tick_nxt;
  logic [7:0]       open_ticks_r, hold_ticks_r, close_ticks_r, alarm_ticks_r;

  logic [IDX_W:0]   key_inc;
  logic             key_last;
  logic [8:0]       tick_inc;
  logic [7:0]       phase_len;
  logic             phase_end;
  logic             mis_key;
  logic             tx_valid, tx_code;
  logic             mem_we;

  // tick length registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_ticks_r  <= OPEN_TICKS_RST;
      hold_ticks_r  <= HOLD_TICKS_RST;
      close_ticks_r <= CLOSE_TICKS_RST;
      alarm_ticks_r <= ALARM_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OPEN:  open_ticks_r  <= cfg_wdata;
        CFG_HOLD:  hold_ticks_r  <= cfg_wdata;
        CFG_CLOSE: close_ticks_r <= cfg_wdata;
        CFG_ALARM: alarm_ticks_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // key counter and phase timer increments
  assign key_inc   = {1'b0, key_r} + (IDX_W + 1)'(1);
  assign key_last  = (key_inc >= PASS_LEN_C);
  assign tick_inc  = {1'b0, tick_r} + 9'd1;
  assign mis_key   = (rd_data != rx_byte);

  // length of the running timed phase
  always_comb begin
    unique case (mode_r)
      MODE_OPEN:  phase_len = open_ticks_r;
      MODE_HOLD:  phase_len = hold_ticks_r;
      MODE_CLOSE: phase_len = close_ticks_r;
      default:    phase_len = alarm_ticks_r;
    endcase
  end
  assign phase_end = (tick_inc >= {1'b0, phase_len});

  // next state for one accepted word
  always_comb begin
    mode_nxt = mode_r;
    key_nxt  = key_r;
    mis_nxt  = mis_r;
    tick_nxt = tick_r;
    tx_valid = 1'b0;
    tx_code  = 1'b0;
    mem_we   = 1'b0;
    if (acc && (func == FUNC_BYTE)) begin
      unique case (mode_r)
        MODE_IDLE: begin
          key_nxt = '0;
          mis_nxt = 1'b0;
          priority if (rx_byte == CMD_SET) begin
            mode_nxt = MODE_NEW1;
          end else if (rx_byte == CMD_CHECK) begin
            mode_nxt = MODE_CHECK;
          end else if (rx_byte == CMD_DOOR) begin
            mode_nxt = MODE_OPEN;
            tick_nxt = '0;
          end else if (rx_byte == CMD_ALARM) begin
            mode_nxt = MODE_ALARM;
            tick_nxt = '0;
          end else begin
            // unknown byte, stay idle
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_NEW1: begin
          mem_we = 1'b1;
          if (key_last) begin
            key_nxt  = '0;
            mis_nxt  = 1'b0;
            mode_nxt = MODE_NEW2;
          end else begin
            key_nxt = key_inc[IDX_W-1:0];
          end
        end
        MODE_NEW2, MODE_CHECK: begin
          if (key_last) begin
            tx_valid = 1'b1;
            tx_code  = !(mis_r || mis_key);
            key_nxt  = '0;
            mis_nxt  = 1'b0;
            mode_nxt = MODE_IDLE;
          end else begin
            key_nxt = key_inc[IDX_W-1:0];
            mis_nxt = mis_r || mis_key;
          end
        end
        MODE_OPEN, MODE_HOLD, MODE_CLOSE, MODE_ALARM: ;
      endcase
    end else if (acc) begin
      unique case (mode_r)
        MODE_OPEN, MODE_HOLD, MODE_CLOSE, MODE_ALARM: begin
          tick_nxt = phase_end ? '0 : tick_inc[7:0];
          if (phase_end) begin
            unique case (mode_r)
              MODE_OPEN: mode_nxt = MODE_HOLD;
              MODE_HOLD: mode_nxt = MODE_CLOSE;
              default:   mode_nxt = MODE_IDLE;
            endcase
          end
        end
        MODE_IDLE, MODE_NEW1, MODE_NEW2, MODE_CHECK: ;
      endcase
    end
  end

  // memory: write the current key slot, prefetch the next one
  assign mem_req = '{we: mem_we, waddr: key_r, wdata: rx_byte, raddr: key_nxt};

  // result for the accepted word, from the state after it
  always_comb begin
    res.tx_valid    = tx_valid;
    res.tx_code     = tx_code;
    res.motor_drive = (mode_nxt == MODE_OPEN)  ? MOTOR_CW  :
                      (mode_nxt == MODE_CLOSE) ? MOTOR_CCW : MOTOR_STOP;
    res.alarm_buzz  = (mode_nxt == MODE_ALARM);
    res.busy_res    = (mode_nxt != MODE_IDLE);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      key_r  <= '0;
      mis_r  <= 1'b0;
      tick_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      key_r  <= key_nxt;
      mis_r  <= mis_nxt;
      tick_r <= tick_nxt;
    end
  end

endmodule

// ----- src/pdlc_outbuf.sv -----
// ----------------------------------------------------------------------------
// Result output stage
// Output register plus one skid word, so input acceptance never waits on
// the downstream ready of the same cycle.
// ----------------------------------------------------------------------------
module pdlc_outbuf
  import pdlc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  res_t in_res,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid_r,
  output res_t out_res_r
);

  logic skid_valid_r;
  res_t skid_res_r;
  logic out_free;

  assign in_ready = !skid_valid_r;
  assign out_free = !out_valid_r || out_ready;

  // occupancy flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || in_valid;
      skid_valid_r <= 1'b0;
    end else if (in_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload words
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_valid_r ? skid_res_r : in_res;
    end else if (in_valid) begin
      skid_res_r <= in_res;
    end
  end

endmodule

// ----- src/password_door_lock_controller_top.sv -----
// ----------------------------------------------------------------------------
// Password door lock controller
// Takes received bytes and timer ticks and drives reply, motor and buzzer.
// ----------------------------------------------------------------------------
// One word is accepted per clock and gives exactly one result word, which
// appears on the output the cycle after acceptance when the output register
// is empty or read in that cycle; otherwise it waits in the skid word. The
// rate is set by the single read-modify-write of the password memory and
// control registers per cycle; the next key slot is prefetched so each
// compare sees its entry on arrival. The output holds two words, so input
// stalls only after two results wait unclaimed. The password memory has
// per-entry valid bits cleared by reset, so no clearing pass is needed after
// reset.
module password_door_lock_controller_top
  import pdlc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // configuration writes
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_wdata,
  // input words
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  input  logic             in_tuser,   // [0] func
  // result words
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [0] tx_valid, [1] tx_code,
                                       // [3:2] motor_drive, [4] alarm_buzz,
                                       // [5] busy_res, [7:6] zero
);

  `include "password_door_lock_controller_top_macros.svh"

  logic       acc;
  logic [7:0] rd_data;
  mem_req_t   mem_req;
  res_t       res;
  res_t       out_res;

  assign acc = in_tvalid && in_tready;

  // sequencer
  pdlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .func      (in_tuser),
    .rx_byte   (in_tdata),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .res       (res)
  );

  // stored password
  pdlc_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mem_req),
    .rd_data_r (rd_data)
  );

  // output register and skid
  pdlc_outbuf u_outbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (acc),
    .in_res      (res),
    .in_ready    (in_tready),
    .out_ready   (out_tready),
    .out_valid_r (out_tvalid),
    .out_res_r   (out_res)
  );

  assign out_tdata = {(OUT_W - $bits(res_t))'(0), out_res};

  // checks
  `PDLC_ASSERT(a_skid_needs_out, !in_tready |-> out_tvalid, "skid full with output empty")
  `PDLC_ASSERT(a_accept_to_out, acc |=> out_tvalid, "accepted word did not reach output")
  `PDLC_ASSERT(a_reply_when_idle, (out_tvalid && out_tdata[0]) |-> !out_tdata[5], "reply while busy")
  `PDLC_ASSERT(a_motor_code, out_tvalid |-> (out_tdata[3:2] != 2'b11), "bad motor code")
  `PDLC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule
